// ----- rtl/core/src_pkg.sv -----
// package for the segment versus rectangle crossing block
// register map codes and pipeline constants, no dependencies
`default_nettype none

package src_pkg;

    // register indexes on the configuration port (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_X_MIN = 2'd0,
        REG_X_MAX = 2'd1,
        REG_Y_MIN = 2'd2,
        REG_Y_MAX = 2'd3
    } reg_idx_t;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_LSB    = 2;

    // register stages from request accept to result strobe
    localparam int PIPE_DEPTH = 4;

endpackage : src_pkg

`default_nettype wire

// ----- rtl/core/src_regs.sv -----
// apb register file holding the rectangle bounds
// depends on src_pkg for the register map
`default_nettype none

module src_regs #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic        [src_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic        [src_pkg::APB_DATA_W-1:0] pwdata,
    output logic             [src_pkg::APB_DATA_W-1:0] prdata,
    output logic                                       pready,
    output logic signed      [COORD_BITS-1:0]          x_min,
    output logic signed      [COORD_BITS-1:0]          x_max,
    output logic signed      [COORD_BITS-1:0]          y_min,
    output logic signed      [COORD_BITS-1:0]          y_max
);

    logic signed [COORD_BITS-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    src_pkg::reg_idx_t            idx;
    logic                         wr_en;

    assign idx    = src_pkg::reg_idx_t'(paddr[src_pkg::APB_ADDR_W-1:src_pkg::REG_LSB]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg <= '0;
            x_max_reg <= '0;
            y_min_reg <= '0;
            y_max_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                src_pkg::REG_X_MIN: x_min_reg <= pwdata[COORD_BITS-1:0];
                src_pkg::REG_X_MAX: x_max_reg <= pwdata[COORD_BITS-1:0];
                src_pkg::REG_Y_MIN: y_min_reg <= pwdata[COORD_BITS-1:0];
                src_pkg::REG_Y_MAX: y_max_reg <= pwdata[COORD_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // reads return the bound sign extended to the bus width
    always_comb
    begin
        case (idx)
            src_pkg::REG_X_MIN: prdata = src_pkg::APB_DATA_W'(x_min_reg);
            src_pkg::REG_X_MAX: prdata = src_pkg::APB_DATA_W'(x_max_reg);
            src_pkg::REG_Y_MIN: prdata = src_pkg::APB_DATA_W'(y_min_reg);
            src_pkg::REG_Y_MAX: prdata = src_pkg::APB_DATA_W'(y_max_reg);
            default:            prdata = '0;
        endcase
    end

    assign x_min = x_min_reg;
    assign x_max = x_max_reg;
    assign y_min = y_min_reg;
    assign y_max = y_max_reg;

endmodule : src_regs

`default_nettype wire

// ----- rtl/core/segment_rect_crossing.sv -----
// segment versus axis-aligned rectangle crossing test, top level
// depends on src_pkg and src_regs
`default_nettype none

// Tests a path segment (start_x, start_y) -> (end_x, end_y) against the
// rectangle [x_min, x_max] x [y_min, y_max] held in the apb registers, and
// reports blocked = 1 when the segment crosses the obstacle. A request is
// taken whenever start is high; busy is always low, so one segment can be
// issued every clock cycle. Each request gives exactly one result, shown on
// blocked for a single cycle with done high; done comes from the valid bits
// v1_reg to v4_reg, which travel with the data through the pipeline. Results
// come out in request order and cannot be held off. The rate
// of one segment per cycle comes from the four-stage datapath: differences
// and inside tests, a bank of twelve multipliers, the cross-product sums,
// then the range checks and the final decision. Bounds should be written
// only while no request is in flight.
module segment_rect_crossing #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // apb configuration port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic        [src_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic        [src_pkg::APB_DATA_W-1:0] pwdata,
    output logic             [src_pkg::APB_DATA_W-1:0] prdata,
    output logic                                       pready,
    // request side
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic signed [COORD_BITS-1:0]          start_x,
    input  wire logic signed [COORD_BITS-1:0]          start_y,
    input  wire logic signed [COORD_BITS-1:0]          end_x,
    input  wire logic signed [COORD_BITS-1:0]          end_y,
    // result side
    output logic                                       done,
    output logic                                       blocked
);

    // widths: coordinate differences, centre factors, products, sums
    localparam int DW   = COORD_BITS + 1;
    localparam int FW   = COORD_BITS + 2;
    localparam int PW   = 2 * DW;
    localparam int QW   = DW + FW;
    localparam int XW   = PW + 1;
    localparam int DOTW = QW + 1;
    localparam int RW   = XW + 1;

    logic signed [COORD_BITS-1:0] x_min, x_max, y_min, y_max;
    logic                         accept;

    src_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .x_min   (x_min),
        .x_max   (x_max),
        .y_min   (y_min),
        .y_max   (y_max)
    );

    // fully pipelined, never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // valid bits travelling with the data
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: differences against the bounds and the inside tests
    // bx/by is the segment direction, cx/cy the offset from the segment
    // start to the left/right and bottom/top edges, w/h the rectangle size
    // ------------------------------------------------------------------
    logic signed [DW-1:0] bx_next, by_next, cxl_next, cxr_next, cyb_next, cyt_next;
    logic signed [DW-1:0] w_next, h_next;
    logic signed [FW-1:0] fx_next, fy_next;
    logic                 s_in_next, e_in_next;

    logic signed [DW-1:0] bx_reg, by_reg, cxl_reg, cxr_reg, cyb_reg, cyt_reg;
    logic signed [DW-1:0] w_reg, h_reg;
    logic signed [FW-1:0] fx_reg, fy_reg;
    logic                 s_in_reg, e_in_reg;

    always_comb
    begin
        bx_next  = DW'(end_x) - DW'(start_x);
        by_next  = DW'(end_y) - DW'(start_y);
        cxl_next = DW'(x_min) - DW'(start_x);
        cxr_next = DW'(x_max) - DW'(start_x);
        cyb_next = DW'(y_min) - DW'(start_y);
        cyt_next = DW'(y_max) - DW'(start_y);
        w_next   = DW'(x_max) - DW'(x_min);
        h_next   = DW'(y_max) - DW'(y_min);
        // twice the vector from the start to the centre, kept exact
        fx_next  = FW'(x_min) + FW'(x_max) - (FW'(start_x) <<< 1);
        fy_next  = FW'(y_min) + FW'(y_max) - (FW'(start_y) <<< 1);
        // strictly inside on both axes
        s_in_next = (start_x > x_min) && (start_x < x_max) &&
                    (start_y > y_min) && (start_y < y_max);
        e_in_next = (end_x > x_min) && (end_x < x_max) &&
                    (end_y > y_min) && (end_y < y_max);
    end

    always_ff @(posedge clk)
    begin
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        cxl_reg  <= cxl_next;
        cxr_reg  <= cxr_next;
        cyb_reg  <= cyb_next;
        cyt_reg  <= cyt_next;
        w_reg    <= w_next;
        h_reg    <= h_next;
        fx_reg   <= fx_next;
        fy_reg   <= fy_next;
        s_in_reg <= s_in_next;
        e_in_reg <= e_in_next;
    end

    // ------------------------------------------------------------------
    // stage 2: products
    // horizontal edges have d = (w, 0), vertical edges d = (0, h), so each
    // cross product reduces to one or two of these terms
    // ------------------------------------------------------------------
    logic signed [PW-1:0] p_byw_next, p_bxh_next, p_cybw_next, p_cytw_next;
    logic signed [PW-1:0] p_cxlh_next, p_cxrh_next, p_cxlby_next, p_cxrby_next;
    logic signed [PW-1:0] p_cybbx_next, p_cytbx_next;
    logic signed [QW-1:0] p_dx_next, p_dy_next;

    logic signed [PW-1:0] p_byw_reg, p_bxh_reg, p_cybw_reg, p_cytw_reg;
    logic signed [PW-1:0] p_cxlh_reg, p_cxrh_reg, p_cxlby_reg, p_cxrby_reg;
    logic signed [PW-1:0] p_cybbx_reg, p_cytbx_reg;
    logic signed [QW-1:0] p_dx_reg, p_dy_reg;
    logic                 s_in2_reg, e_in2_reg;

    always_comb
    begin
        p_byw_next   = PW'(by_reg) * PW'(w_reg);
        p_bxh_next   = PW'(bx_reg) * PW'(h_reg);
        p_cybw_next  = PW'(cyb_reg) * PW'(w_reg);
        p_cytw_next  = PW'(cyt_reg) * PW'(w_reg);
        p_cxlh_next  = PW'(cxl_reg) * PW'(h_reg);
        p_cxrh_next  = PW'(cxr_reg) * PW'(h_reg);
        p_cxlby_next = PW'(cxl_reg) * PW'(by_reg);
        p_cxrby_next = PW'(cxr_reg) * PW'(by_reg);
        p_cybbx_next = PW'(cyb_reg) * PW'(bx_reg);
        p_cytbx_next = PW'(cyt_reg) * PW'(bx_reg);
        p_dx_next    = QW'(bx_reg) * QW'(fx_reg);
        p_dy_next    = QW'(by_reg) * QW'(fy_reg);
    end

    always_ff @(posedge clk)
    begin
        p_byw_reg   <= p_byw_next;
        p_bxh_reg   <= p_bxh_next;
        p_cybw_reg  <= p_cybw_next;
        p_cytw_reg  <= p_cytw_next;
        p_cxlh_reg  <= p_cxlh_next;
        p_cxrh_reg  <= p_cxrh_next;
        p_cxlby_reg <= p_cxlby_next;
        p_cxrby_reg <= p_cxrby_next;
        p_cybbx_reg <= p_cybbx_next;
        p_cytbx_reg <= p_cytbx_next;
        p_dx_reg    <= p_dx_next;
        p_dy_reg    <= p_dy_next;
        s_in2_reg   <= s_in_reg;
        e_in2_reg   <= e_in_reg;
    end

    // ------------------------------------------------------------------
    // stage 3: denominators, t and u numerators per edge, escape dot
    // bottom and left share u, as they share the corner (x_min, y_min)
    // ------------------------------------------------------------------
    logic signed [XW-1:0]   den_h_next, den_v_next;
    logic signed [XW-1:0]   tn_b_next, tn_t_next, tn_l_next, tn_r_next;
    logic signed [XW-1:0]   un_bl_next, un_t_next, un_r_next;
    logic signed [DOTW-1:0] dot_next;

    logic signed [XW-1:0]   den_h_reg, den_v_reg;
    logic signed [XW-1:0]   tn_b_reg, tn_t_reg, tn_l_reg, tn_r_reg;
    logic signed [XW-1:0]   un_bl_reg, un_t_reg, un_r_reg;
    logic signed [DOTW-1:0] dot_reg;
    logic                   s_in3_reg, e_in3_reg;

    always_comb
    begin
        den_h_next = XW'(0) - XW'(p_byw_reg);
        den_v_next = XW'(p_bxh_reg);
        tn_b_next  = XW'(0) - XW'(p_cybw_reg);
        tn_t_next  = XW'(0) - XW'(p_cytw_reg);
        tn_l_next  = XW'(p_cxlh_reg);
        tn_r_next  = XW'(p_cxrh_reg);
        un_bl_next = XW'(p_cxlby_reg) - XW'(p_cybbx_reg);
        un_t_next  = XW'(p_cxlby_reg) - XW'(p_cytbx_reg);
        un_r_next  = XW'(p_cxrby_reg) - XW'(p_cybbx_reg);
        dot_next   = DOTW'(p_dx_reg) + DOTW'(p_dy_reg);
    end

    always_ff @(posedge clk)
    begin
        den_h_reg <= den_h_next;
        den_v_reg <= den_v_next;
        tn_b_reg  <= tn_b_next;
        tn_t_reg  <= tn_t_next;
        tn_l_reg  <= tn_l_next;
        tn_r_reg  <= tn_r_next;
        un_bl_reg <= un_bl_next;
        un_t_reg  <= un_t_next;
        un_r_reg  <= un_r_next;
        dot_reg   <= dot_next;
        s_in3_reg <= s_in2_reg;
        e_in3_reg <= e_in2_reg;
    end

    // ------------------------------------------------------------------
    // stage 4: num/den in [0,1] by signs, then the decision
    // ------------------------------------------------------------------

    // den is known nonzero where the result matters
    function automatic logic in_unit(input logic signed [XW-1:0] num,
                                     input logic signed [XW-1:0] den);
        logic signed [RW-1:0] diff;
        logic                 num_neg, num_zero, diff_neg, diff_zero;
        diff      = RW'(num) - RW'(den);
        num_neg   = num[XW-1];
        num_zero  = (num == '0);
        diff_neg  = diff[RW-1];
        diff_zero = (diff == '0);
        if (!den[XW-1])
            in_unit = !num_neg && (diff_neg || diff_zero);
        else
            in_unit = (num_neg || num_zero) && !diff_neg;
    endfunction

    logic hit_b, hit_t, hit_l, hit_r, edge_hit;
    logic blocked_next;
    logic blocked_reg;

    always_comb
    begin
        // parallel or degenerate edges never hit
        hit_b = (den_h_reg != '0) && in_unit(tn_b_reg, den_h_reg) &&
                in_unit(un_bl_reg, den_h_reg);
        hit_t = (den_h_reg != '0) && in_unit(tn_t_reg, den_h_reg) &&
                in_unit(un_t_reg, den_h_reg);
        hit_l = (den_v_reg != '0) && in_unit(tn_l_reg, den_v_reg) &&
                in_unit(un_bl_reg, den_v_reg);
        hit_r = (den_v_reg != '0) && in_unit(tn_r_reg, den_v_reg) &&
                in_unit(un_r_reg, den_v_reg);
        edge_hit = hit_b || hit_t || hit_l || hit_r;

        if (s_in3_reg && e_in3_reg)
            blocked_next = 1'b1;
        else if (s_in3_reg && dot_reg[DOTW-1])
            blocked_next = 1'b0;   // escape: leaving away from the centre
        else
            blocked_next = edge_hit;
    end

    always_ff @(posedge clk)
    begin
        blocked_reg <= blocked_next;
    end

    assign done    = v4_reg;
    assign blocked = blocked_reg;

endmodule : segment_rect_crossing

`default_nettype wire

// ----- rtl/core/src_check.sv -----
// port-level checker for segment_rect_crossing, bound to the top level
// depends on src_pkg for the pipeline depth
`default_nettype none

module src_check (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire logic pready
);

    // every accepted request gives its result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(src_pkg::PIPE_DEPTH) done)
        else $error("request without result at fixed latency");

    // no result strobe without a matching request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##(src_pkg::PIPE_DEPTH) !done)
        else $error("result strobe without request");

    // the pipeline never pushes back
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule : src_check

bind segment_rect_crossing src_check u_src_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .pready (pready)
);

`default_nettype wire
